// ===== rtl/pla_pkg.sv =====
// Package for the advertising payload leak audit block.
// Holds the transaction payload types, the parse phase type and the AD type codes.
// No dependencies; every other file of the block imports it.
package pla_pkg;

	localparam int RecordBytes = 31;

	// AD structure types whose value bytes are fully or partly preserved.
	localparam logic [7:0] AD_FLAGS         = 8'h01;
	localparam logic [7:0] AD_UUID16_PART   = 8'h02;
	localparam logic [7:0] AD_UUID16_FULL   = 8'h03;
	localparam logic [7:0] AD_TX_POWER      = 8'h0A;
	localparam logic [7:0] AD_APPEARANCE    = 8'h19;
	localparam logic [7:0] AD_SERVICE_DATA  = 8'h16;
	localparam logic [7:0] AD_MANUFACTURER  = 8'hFF;

	// Beacon prefix of manufacturer data: company id 0x004C, then 02 15.
	localparam logic [7:0] PFX_BYTE0 = 8'h4C;
	localparam logic [7:0] PFX_BYTE1 = 8'h00;
	localparam logic [7:0] PFX_BYTE2 = 8'h02;
	localparam logic [7:0] PFX_BYTE3 = 8'h15;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_TYPE,
		PH_VAL,
		PH_STOP
	} phase_t;

	typedef struct packed {
		logic [7:0]  ad_byte;
		logic [4:0]  ad_length;
		logic [31:0] random_mask;
		logic [4:0]  name_offset;
		logic [4:0]  name_length;
		logic        last_slot;
	} pla_item_t;

	typedef struct packed {
		logic [4:0] leaked_bytes;
		logic [4:0] name_hits;
	} pla_result_t;

	// Verdicts of manufacturer value byte 2, held until byte 3 arrives.
	typedef struct packed {
		logic pending;
		logic masked;
		logic named;
	} held_t;

endpackage

// ===== rtl/pla_if.sv =====
// Handshake interfaces for the input slot channel and the result channel.
// Depends on pla_pkg for the payload types.
interface pla_item_if;
	import pla_pkg::*;
	logic      valid;
	logic      ready;
	pla_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pla_result_if;
	import pla_pkg::*;
	logic        valid;
	logic        ready;
	pla_result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/adv_payload_leak_audit_core.sv =====
// Top level of the advertising payload leak audit block.
// Depends on pla_pkg and on the interfaces in pla_if.sv.
//
// Use: each transaction on the item channel carries one byte slot of an
// advertising record, slot 0 first, together with the record's valid length,
// random mask and local name region. A record ends at a slot with last_slot
// set or at slot RECORD_BYTES - 1. For that slot one transaction leaves on the
// result channel with the leaked and named byte counts; all other slots give
// no result.
// Throughput is one slot per cycle while no record end waits on a stalled result
// register: every slot is judged by a few compares between the input register and
// the parse state, which is registered. The final slot of a record passes through
// the input register, then its counts go to the result register.
// Reset clears the parse state, the counts and both valid flags; the block
// is ready to take a slot as soon as reset is released.
// When the receiver stalls, the result register holds its transaction and the
// block keeps taking slots until a second record end would need the register;
// that slot then waits in the input register and ready falls.
module adv_payload_leak_audit_core #(
	parameter int RECORD_BYTES = pla_pkg::RecordBytes
) (
	input logic          clk,
	input logic          arst_n,
	pla_item_if.sink     item,
	pla_result_if.source result
);
	import pla_pkg::*;

	localparam int PW = ($clog2(RECORD_BYTES) > 5) ? $clog2(RECORD_BYTES) : 5;
	localparam int CW = PW + 4;
	localparam logic [PW-1:0] LAST_POS = PW'(RECORD_BYTES - 1);

	pla_item_t   item_s1;
	logic        item_vld_s1;
	logic [PW-1:0] slot_pos_q;
	phase_t      phase_q, phase_d;
	logic [4:0]  struct_end_q, struct_end_d;
	logic [4:0]  value_start_q, value_start_d;
	logic [7:0]  stype_q, stype_d;
	logic [1:0]  prefix_q, prefix_d;
	held_t       held_q, held_d;
	logic [4:0]  leak_q, named_q;
	pla_result_t result_q;
	logic        result_vld_q;

	logic [CW-1:0] p_ext, len_ext, byte_ext;
	logic [4:0]  p_lo, off;
	logic        rec_end, stop_len, masked, named, vlen_ge4, pres;
	logic        cur_tally, held_tally;
	logic [1:0]  leak_inc, named_inc;
	logic [5:0]  leak_sum, named_sum;
	logic [4:0]  leak_new, named_new;
	logic        out_free, s1_go;

	assign p_ext    = CW'(slot_pos_q);
	assign len_ext  = CW'(item_s1.ad_length);
	assign byte_ext = CW'(item_s1.ad_byte);
	assign p_lo     = slot_pos_q[4:0];
	assign off      = p_lo - value_start_q;
	assign rec_end  = item_s1.last_slot || (slot_pos_q == LAST_POS);
	assign stop_len = (p_ext + CW'(1) >= len_ext) || (item_s1.ad_byte == 8'h00)
		|| (p_ext + CW'(1) + byte_ext > len_ext);
	assign masked   = (p_ext < CW'(32)) && item_s1.random_mask[p_lo];
	assign named    = (item_s1.name_length != 5'd0)
		&& (p_ext >= CW'(item_s1.name_offset))
		&& (p_ext < CW'(item_s1.name_offset) + CW'(item_s1.name_length));
	assign vlen_ge4 = (struct_end_q - value_start_q) >= 5'd3;

	// Parse phase sequencing.
	always_comb begin
		case (phase_q)
			PH_LEN:  phase_d = stop_len ? PH_STOP : PH_TYPE;
			PH_TYPE: phase_d = (CW'(struct_end_q) == p_ext) ? PH_LEN : PH_VAL;
			PH_VAL:  phase_d = (CW'(struct_end_q) == p_ext) ? PH_LEN : PH_VAL;
			default: phase_d = PH_STOP;
		endcase
	end

	// Structure bookkeeping and the verdict for the current value byte.
	always_comb begin
		struct_end_d  = struct_end_q;
		value_start_d = value_start_q;
		stype_d       = stype_q;
		prefix_d      = prefix_q;
		held_d        = held_q;
		pres          = 1'b0;
		cur_tally     = 1'b0;
		held_tally    = 1'b0;
		case (phase_q)
			PH_LEN: begin
				if (!stop_len) begin
					struct_end_d  = 5'(p_ext + byte_ext);
					value_start_d = p_lo + 5'd2;
				end
			end
			PH_TYPE: begin
				stype_d  = item_s1.ad_byte;
				prefix_d = 2'd0;
				held_d   = '0;
			end
			PH_VAL: begin
				cur_tally = 1'b1;
				case (stype_q) inside
					AD_FLAGS, AD_UUID16_PART, AD_UUID16_FULL, AD_TX_POWER,
					AD_APPEARANCE: pres = 1'b1;
					AD_SERVICE_DATA: pres = off < 5'd2;
					AD_MANUFACTURER: begin
						if (off == 5'd0) begin
							prefix_d = (item_s1.ad_byte == PFX_BYTE0) ? 2'd1 : 2'd0;
							pres     = 1'b1;
						end else if (off == 5'd1) begin
							prefix_d = (prefix_q == 2'd1 && item_s1.ad_byte == PFX_BYTE1)
								? 2'd2 : 2'd0;
							pres     = 1'b1;
						end else if (off == 5'd2 && vlen_ge4) begin
							// Byte 2 is judged only once byte 3 shows the full prefix.
							prefix_d  = (prefix_q == 2'd2 && item_s1.ad_byte == PFX_BYTE2)
								? 2'd3 : 2'd0;
							held_d    = '{pending: 1'b1, masked: masked, named: named};
							cur_tally = 1'b0;
						end else if (off == 5'd3 && held_q.pending) begin
							pres       = (prefix_q == 2'd3) && (item_s1.ad_byte == PFX_BYTE3);
							held_tally = 1'b1;
							held_d     = '0;
						end
					end
					default: pres = 1'b0;
				endcase
			end
			default: pres = 1'b0;
		endcase
	end

	// A byte 2 still held at the record end counts as not preserved.
	always_comb begin
		leak_inc  = 2'd0;
		named_inc = 2'd0;
		if (held_tally && !pres && !held_q.masked) begin
			if (held_q.named) named_inc = named_inc + 2'd1;
			else leak_inc = leak_inc + 2'd1;
		end
		if (cur_tally && !pres && !masked) begin
			if (named) named_inc = named_inc + 2'd1;
			else leak_inc = leak_inc + 2'd1;
		end
		if (rec_end && held_d.pending && !held_d.masked) begin
			if (held_d.named) named_inc = named_inc + 2'd1;
			else leak_inc = leak_inc + 2'd1;
		end
	end

	assign leak_sum  = 6'(leak_q) + 6'(leak_inc);
	assign named_sum = 6'(named_q) + 6'(named_inc);
	assign leak_new  = leak_sum[5] ? 5'd31 : leak_sum[4:0];
	assign named_new = named_sum[5] ? 5'd31 : named_sum[4:0];

	assign out_free   = !result_vld_q || result.ready;
	assign s1_go      = item_vld_s1 && (!rec_end || out_free);
	assign item.ready = !item_vld_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (item.ready) begin
			item_vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_pos_q    <= '0;
			phase_q       <= PH_LEN;
			struct_end_q  <= '0;
			value_start_q <= '0;
			stype_q       <= '0;
			prefix_q      <= '0;
			held_q        <= '0;
			leak_q        <= '0;
			named_q       <= '0;
		end else if (s1_go) begin
			if (rec_end) begin
				slot_pos_q    <= '0;
				phase_q       <= PH_LEN;
				struct_end_q  <= '0;
				value_start_q <= '0;
				stype_q       <= '0;
				prefix_q      <= '0;
				held_q        <= '0;
				leak_q        <= '0;
				named_q       <= '0;
			end else begin
				slot_pos_q    <= slot_pos_q + PW'(1);
				phase_q       <= phase_d;
				struct_end_q  <= struct_end_d;
				value_start_q <= value_start_d;
				stype_q       <= stype_d;
				prefix_q      <= prefix_d;
				held_q        <= held_d;
				leak_q        <= leak_new;
				named_q       <= named_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_vld_q <= 1'b0;
		end else if (s1_go && rec_end) begin
			result_vld_q <= 1'b1;
		end else if (result.ready) begin
			result_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && rec_end) begin
			result_q <= '{leaked_bytes: leak_new, name_hits: named_new};
		end
	end

	assign result.valid = result_vld_q;
	assign result.data  = result_q;

	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && !rec_end && phase_q == PH_STOP |=> phase_q == PH_STOP)
		else $error("parse left the stopped phase inside a record");

	a_held_manuf: assert property (@(posedge clk) disable iff (!arst_n)
		held_q.pending |-> stype_q == AD_MANUFACTURER)
		else $error("held byte pending outside manufacturer data");

	a_record_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && rec_end |=> slot_pos_q == '0 && leak_q == 5'd0 && named_q == 5'd0)
		else $error("record state not cleared after record end");

	a_val_in_struct: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VAL |-> p_ext <= CW'(struct_end_q))
		else $error("value slot beyond the end of its structure");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_vld_q && !result.ready |-> !(s1_go && rec_end))
		else $error("result register overwritten while stalled");

endmodule

// ===== tb/adv_payload_leak_audit_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for adv_payload_leak_audit_core: streams advertising records slot by
// slot and checks every record's leaked and named byte counts against an in-bench model.
// Depends on pla_pkg and on the handshake interfaces in pla_if.sv.
module adv_payload_leak_audit_core_test;
	import pla_pkg::*;

	localparam int IdleLimit = 2000;
	localparam int RandomItems = 380;
	localparam int RandomRecords = 10;
	localparam logic [7:0] AD_LOCAL_NAME = 8'h09;

	typedef enum int {FLOW_FREE, FLOW_CHOPPY, FLOW_CHOKED} flow_t;

	logic clk = 1'b0;
	logic arst_n;

	pla_item_if item_ch ();
	pla_result_if result_ch ();

	adv_payload_leak_audit_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model of the record walk and of the running counts.
	phase_t      scan_phase;
	logic [4:0]  scan_pos;
	logic [4:0]  struct_last;
	logic [4:0]  value_base;
	logic [7:0]  struct_kind;
	logic [1:0]  beacon_run;
	held_t       held_byte2;
	logic [4:0]  leak_count;
	logic [4:0]  named_count;
	pla_result_t expected_counts[$];

	logic [7:0]  record_bytes[$];
	flow_t       ready_mode = FLOW_FREE;
	logic [15:0] ready_bits = 16'hFFFF;
	logic [5:0]  ready_tick = '0;
	int burst_left = 0;
	int items_sent = 0;
	int live_items = 0;
	int records_sent = 0;
	int results_seen = 0;
	int errors = 0;
	int idle_cycles = 0;

	function automatic void clear_audit();
		scan_pos = '0;
		scan_phase = PH_LEN;
		struct_last = '0;
		value_base = '0;
		struct_kind = '0;
		beacon_run = '0;
		held_byte2 = '0;
		leak_count = '0;
		named_count = '0;
	endfunction

	function automatic void count_byte(input bit kept, input bit masked, input bit in_name);
		if (kept || masked)
			return;
		if (in_name) begin
			if (named_count != 5'd31)
				named_count = named_count + 5'd1;
		end else if (leak_count != 5'd31) begin
			leak_count = leak_count + 5'd1;
		end
	endfunction

	function automatic void audit_slot(input pla_item_t it);
		int pos;
		int off;
		int vlen;
		int name_end;
		bit kept;
		bit masked;
		bit in_name;
		bit deferred;
		pos = int'(scan_pos);
		if (scan_phase != PH_STOP)
			live_items++;
		case (scan_phase)
			PH_LEN: begin
				if (pos + 1 >= int'(it.ad_length) || it.ad_byte == 8'h00 ||
				    pos + 1 + int'(it.ad_byte) > int'(it.ad_length)) begin
					scan_phase = PH_STOP;
				end else begin
					struct_last = 5'(pos + int'(it.ad_byte));
					value_base = 5'(pos + 2);
					scan_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				struct_kind = it.ad_byte;
				beacon_run = '0;
				held_byte2 = '0;
				scan_phase = (int'(struct_last) == pos) ? PH_LEN : PH_VAL;
			end
			PH_VAL: begin
				off = pos - int'(value_base);
				vlen = int'(struct_last) - int'(value_base) + 1;
				masked = it.random_mask[pos];
				name_end = int'(it.name_offset) + int'(it.name_length);
				in_name = it.name_length != 5'd0 && pos >= int'(it.name_offset) &&
				          pos < name_end;
				kept = 1'b0;
				deferred = 1'b0;
				case (struct_kind)
					AD_FLAGS, AD_UUID16_PART, AD_UUID16_FULL, AD_TX_POWER, AD_APPEARANCE:
						kept = 1'b1;
					AD_SERVICE_DATA:
						kept = off < 2;
					AD_MANUFACTURER: begin
						if (off == 0) begin
							beacon_run = (it.ad_byte == PFX_BYTE0) ? 2'd1 : 2'd0;
							kept = 1'b1;
						end else if (off == 1) begin
							beacon_run = (beacon_run == 2'd1 && it.ad_byte == PFX_BYTE1)
								? 2'd2 : 2'd0;
							kept = 1'b1;
						end else if (off == 2 && vlen >= 4) begin
							// The verdict on this byte waits for the fourth prefix byte.
							beacon_run = (beacon_run == 2'd2 && it.ad_byte == PFX_BYTE2)
								? 2'd3 : 2'd0;
							held_byte2 = '{pending: 1'b1, masked: masked, named: in_name};
							deferred = 1'b1;
						end else if (off == 3 && held_byte2.pending) begin
							kept = beacon_run == 2'd3 && it.ad_byte == PFX_BYTE3;
							count_byte(kept, held_byte2.masked, held_byte2.named);
							held_byte2 = '0;
						end
					end
					default: ;
				endcase
				if (!deferred)
					count_byte(kept, masked, in_name);
				if (int'(struct_last) == pos)
					scan_phase = PH_LEN;
			end
			default: ;
		endcase
		if (it.last_slot || pos + 1 >= RecordBytes) begin
			// A held manufacturer byte that never saw its partner counts as unprotected.
			if (held_byte2.pending)
				count_byte(1'b0, held_byte2.masked, held_byte2.named);
			expected_counts.push_back(
				pla_result_t'{leaked_bytes: leak_count, name_hits: named_count});
			clear_audit();
		end else begin
			scan_pos = 5'(pos + 1);
		end
	endfunction

	task automatic send_slot(input pla_item_t it);
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		items_sent++;
		burst_left--;
		audit_slot(it);
	endtask

	task automatic send_record(input logic [4:0] len, input logic [31:0] mask,
	                           input logic [4:0] noff, input logic [4:0] nlen, input int jitter);
		pla_item_t it;
		for (int i = 0; i < record_bytes.size(); i++) begin
			it.ad_byte = record_bytes[i];
			it.ad_length = len;
			it.random_mask = mask;
			it.name_offset = noff;
			it.name_length = nlen;
			// Now and then a slot carries record fields of its own.
			if (int'($urandom_range(1, 100)) <= jitter) begin
				it.ad_length = 5'($urandom);
				it.random_mask = $urandom;
				it.name_offset = 5'($urandom);
				it.name_length = 5'($urandom);
			end
			it.last_slot = (i == record_bytes.size() - 1) &&
			               (i < RecordBytes - 1 || $urandom_range(0, 1) == 1);
			send_slot(it);
		end
		records_sent++;
	endtask

	task automatic wait_for_results();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_counts.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_records();
		ready_mode = FLOW_CHOPPY;
		// Full beacon prefix, then one unprotected manufacturer byte.
		record_bytes = '{8'h06, AD_MANUFACTURER, PFX_BYTE0, PFX_BYTE1, PFX_BYTE2, PFX_BYTE3,
			8'hAA};
		send_record(5'd7, 32'h0000_0000, 5'd0, 5'd0, 0);
		// The record ends while the third manufacturer byte is still held.
		record_bytes = '{8'h05, AD_MANUFACTURER, PFX_BYTE0, PFX_BYTE1, PFX_BYTE2};
		send_record(5'd31, 32'h0000_0000, 5'd4, 5'd31, 0);
		// Zero valid length stops the walk at once.
		record_bytes = '{8'hFF, 8'h00, 8'hFF};
		send_record(5'd0, 32'hFFFF_FFFF, 5'd31, 5'd31, 0);
		// Unknown type: leaks, one named byte and one masked byte.
		record_bytes = '{8'h05, 8'h20, 8'hFF, 8'h00, 8'h5A, 8'h11};
		send_record(5'd6, 32'h0000_0020, 5'd4, 5'd1, 0);
		// Structure overruns the valid length.
		record_bytes = '{8'h04, AD_TX_POWER};
		send_record(5'd3, 32'h0000_0000, 5'd0, 5'd0, 0);
		// Type-only structure, service data, then the walk reaches the valid length.
		record_bytes = '{8'h01, AD_FLAGS, 8'h03, AD_SERVICE_DATA, 8'h12, 8'h34, 8'h02};
		send_record(5'd6, 32'h0000_0000, 5'd0, 5'd0, 0);
	endtask

	task automatic test_record_ends_under_stall();
		// Tiny records sent back to back, so that record ends pile up behind a slow receiver.
		ready_mode = FLOW_CHOKED;
		burst_left = 300;
		repeat (24) begin
			record_bytes.delete();
			repeat ($urandom_range(1, 3)) record_bytes.push_back(8'($urandom_range(0, 3)));
			send_record(5'($urandom), $urandom, 5'($urandom), 5'($urandom), 0);
		end
		wait_for_results();
	endtask

	task automatic test_random_records();
		int slots;
		int room;
		int vlen;
		int body_end;
		int name_at;
		int name_span;
		int first_item;
		int first_record;
		logic [7:0] kind;
		logic [7:0] b;
		logic [4:0] len;
		logic [4:0] noff;
		logic [4:0] nlen;
		logic [31:0] mask;
		bit beacon;
		first_item = items_sent;
		first_record = records_sent;
		while (items_sent - first_item < RandomItems || records_sent - first_record < RandomRecords)
		begin
			case ($urandom_range(0, 3))
				0: ready_mode = FLOW_FREE;
				1: ready_mode = FLOW_CHOKED;
				default: ready_mode = FLOW_CHOPPY;
			endcase
			slots = ($urandom_range(0, 9) < 4) ? RecordBytes
				: int'($urandom_range(1, RecordBytes - 1));
			record_bytes.delete();
			name_at = -1;
			name_span = 0;
			while (record_bytes.size() + 2 <= slots && $urandom_range(0, 7) != 0) begin
				room = slots - record_bytes.size() - 1;
				vlen = $urandom_range(0, room - 1);
				if (vlen > 6 && $urandom_range(0, 1) == 1)
					vlen = $urandom_range(0, 6);
				case ($urandom_range(0, 11))
					0: kind = AD_FLAGS;
					1: kind = AD_UUID16_PART;
					2: kind = AD_UUID16_FULL;
					3: kind = AD_TX_POWER;
					4: kind = AD_APPEARANCE;
					5: kind = AD_SERVICE_DATA;
					6, 7, 8: kind = AD_MANUFACTURER;
					9: kind = AD_LOCAL_NAME;
					default: kind = 8'($urandom);
				endcase
				record_bytes.push_back(8'(vlen + 1));
				record_bytes.push_back(kind);
				if (kind == AD_LOCAL_NAME) begin
					name_at = record_bytes.size();
					name_span = vlen;
				end
				beacon = kind == AD_MANUFACTURER && $urandom_range(0, 2) != 0;
				for (int k = 0; k < vlen; k++) begin
					b = 8'($urandom);
					// Prefix bytes are spoilt now and then, so that each step of the match can fail.
					if (beacon && $urandom_range(0, 7) != 0) begin
						case (k)
							0: b = PFX_BYTE0;
							1: b = PFX_BYTE1;
							2: b = PFX_BYTE2;
							3: b = PFX_BYTE3;
							default: ;
						endcase
					end
					record_bytes.push_back(b);
				end
			end
			body_end = record_bytes.size();
			while (record_bytes.size() < slots)
				record_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
			if ($urandom_range(0, 5) == 0)
				record_bytes[$urandom_range(0, slots - 1)] = 8'($urandom);
			len = ($urandom_range(0, 3) != 0) ? 5'(body_end) : 5'($urandom);
			if (name_at >= 0 && $urandom_range(0, 3) != 0) begin
				noff = 5'(name_at);
				nlen = 5'(name_span);
			end else begin
				noff = 5'($urandom);
				nlen = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom);
			end
			case ($urandom_range(0, 5))
				0: mask = '0;
				1: mask = '1;
				default: mask = $urandom;
			endcase
			send_record(len, mask, noff, nlen, ($urandom_range(0, 4) == 0) ? 10 : 0);
			if ($urandom_range(0, 15) == 0)
				wait_for_results();
		end
	endtask

	// Receiver: a fresh 16-bit ready pattern whenever the tick counter wraps, each with at least one ready bit set.
	always @(posedge clk) begin
		if (ready_tick == 6'd0) begin
			case (ready_mode)
				FLOW_FREE: ready_bits = 16'hFFFF;
				FLOW_CHOPPY: ready_bits = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
				default: ready_bits = 16'($urandom & $urandom & $urandom)
					| (16'd1 << $urandom_range(0, 15));
			endcase
		end
		result_ch.ready <= ready_bits[ready_tick[3:0]];
		ready_tick = ready_tick + 6'd1;
	end

	always @(posedge clk) begin
		pla_result_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			results_seen++;
			if (expected_counts.size() == 0) begin
				if (errors < 10)
					$display("Result transaction with no record outstanding: leaked %0d named %0d",
					         result_ch.data.leaked_bytes, result_ch.data.name_hits);
				errors++;
			end else begin
				want = expected_counts.pop_front();
				if (result_ch.data.leaked_bytes !== want.leaked_bytes ||
				    result_ch.data.name_hits !== want.name_hits) begin
					if (errors < 10)
						$display({"Count mismatch on result %0d: expected leaked %0d named %0d,",
						          " got leaked %0d named %0d"},
						         results_seen, want.leaked_bytes, want.name_hits,
						         result_ch.data.leaked_bytes, result_ch.data.name_hits);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("No transaction for %0d cycles with %0d results outstanding",
				         IdleLimit, expected_counts.size());
				$display("adv_payload_leak_audit_core_test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		clear_audit();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_records();
		wait_for_results();
		test_record_ends_under_stall();
		test_random_records();
		wait_for_results();
		repeat (4) @(posedge clk);
		if (expected_counts.size() != 0) begin
			$display("%0d expected results never arrived", expected_counts.size());
			errors++;
		end
		$display("Sent %0d slots in %0d records, %0d of them walked by the parser; %0d results checked.",
		         items_sent, records_sent, live_items, results_seen);
		$display("Failures found: %0d", errors);
		if (errors == 0)
			$display("adv_payload_leak_audit_core_test passed");
		else
			$display("adv_payload_leak_audit_core_test failed");
		$finish;
	end

endmodule
